/* hdl/nhfst_pkg.sv */
// shared types and item codes for the nth-hit fault slot table
`timescale 1ns / 1ps

package nhfst_pkg;

    localparam int KIND_W  = 2;
    localparam int SITE_W  = 8;
    localparam int COUNT_W = 32;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [SITE_W-1:0]  t_site;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_kind KIND_ARM     = 2'd0;
    localparam t_kind KIND_CONSUME = 2'd1;
    localparam t_kind KIND_CLEAR   = 2'd2;

    localparam t_site SITE_EMPTY = '0;

endpackage

/* hdl/nhfst_slot_update.sv */
// next-state logic of the slot table for one item, plus the fire flag
`timescale 1ns / 1ps

module nhfst_slot_update #(
    parameter int NUM_SLOTS = 4
) (
    input  nhfst_pkg::t_kind                    i_kind,
    input  nhfst_pkg::t_site                    i_site,
    input  nhfst_pkg::t_count                   i_count,
    input  nhfst_pkg::t_site  [NUM_SLOTS-1:0]   i_slot_site,
    input  nhfst_pkg::t_count [NUM_SLOTS-1:0]   i_slot_cnt,
    output nhfst_pkg::t_site  [NUM_SLOTS-1:0]   o_slot_site,
    output nhfst_pkg::t_count [NUM_SLOTS-1:0]   o_slot_cnt,
    output logic                                o_fire
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic              hit_found;
    logic              free_found;
    logic              cons_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  cons_idx;
    logic [IDX_W-1:0]  arm_idx;
    nhfst_pkg::t_count dec_cnt;

    // priority search: first matching slot, first empty slot, first live match
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        cons_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        cons_idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!hit_found && i_slot_site[i] == i_site) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!free_found && i_slot_site[i] == nhfst_pkg::SITE_EMPTY) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (!cons_found && i_slot_site[i] == i_site && i_slot_cnt[i] != '0) begin
                cons_found = 1'b1;
                cons_idx   = IDX_W'(i);
            end
        end
    end

    assign arm_idx = hit_found ? hit_idx : (free_found ? free_idx : '0);
    assign dec_cnt = i_slot_cnt[cons_idx] - nhfst_pkg::COUNT_W'(1);

    always_comb begin
        o_slot_site = i_slot_site;
        o_slot_cnt  = i_slot_cnt;
        o_fire      = 1'b0;
        case (i_kind)
            nhfst_pkg::KIND_ARM: begin
                if (i_site != nhfst_pkg::SITE_EMPTY) begin
                    if (i_count == '0) begin
                        // disarm every copy of the site
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (i_slot_site[i] == i_site) begin
                                o_slot_site[i] = nhfst_pkg::SITE_EMPTY;
                                o_slot_cnt[i]  = '0;
                            end
                        end
                    end else begin
                        o_slot_site[arm_idx] = i_site;
                        o_slot_cnt[arm_idx]  = i_count;
                    end
                end
            end
            nhfst_pkg::KIND_CONSUME: begin
                if (i_site != nhfst_pkg::SITE_EMPTY && cons_found) begin
                    o_slot_cnt[cons_idx] = dec_cnt;
                    if (dec_cnt == '0) begin
                        o_slot_site[cons_idx] = nhfst_pkg::SITE_EMPTY;
                        o_fire                = 1'b1;
                    end
                end
            end
            nhfst_pkg::KIND_CLEAR: begin
                o_slot_site = '0;
                o_slot_cnt  = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/nth_hit_fault_slot_table.sv */
// top level of the nth-hit fault slot table
`timescale 1ns / 1ps

// nth-hit fault slot table. holds NUM_SLOTS slots, each a site id (0 = empty)
// and a 32-bit countdown. an arm item with a nonzero count loads the slot that
// already holds the site, else the first empty slot, else slot 0; an arm item
// with count 0 empties every slot holding the site. a consume item counts down
// the first live slot holding the site and raises fire when it reaches zero,
// which frees the slot. a clear item empties the table. site 0 leaves the table
// alone for arm and consume items, and kind 3 always does. every item gives
// exactly one result item (fire). throughput is one item per cycle while o_stall
// is low: the whole table update is one combinational pass between the input
// register and the result register, and the table itself is written on the
// same edge that loads the result. an accepted item waits in the input register
// until the result register can take it, and is then offered as a result. the
// input register lets a new item be taken while a finished result still waits
// in the result register; o_stall rises only when both the input register and
// the result register are full and the consumer stalls.
module nth_hit_fault_slot_table #(
    parameter int NUM_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_site,
    input  logic [31:0] i_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_fire
);

    // input stage
    logic              r_in_valid;
    nhfst_pkg::t_kind  r_kind;
    nhfst_pkg::t_site  r_site;
    nhfst_pkg::t_count r_count;

    // result stage
    logic r_out_valid;
    logic r_fire;

    // slot table
    nhfst_pkg::t_site  [NUM_SLOTS-1:0] r_slot_site;
    nhfst_pkg::t_count [NUM_SLOTS-1:0] r_slot_cnt;
    nhfst_pkg::t_site  [NUM_SLOTS-1:0] n_slot_site;
    nhfst_pkg::t_count [NUM_SLOTS-1:0] n_slot_cnt;
    logic                              n_fire;

    logic out_blocked;
    logic advance;
    logic in_load;

    // result register can't take a new item while its current one is stalled
    assign out_blocked = r_out_valid && i_stall;
    // the item in the input register moves into the result register
    assign advance     = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;
    assign in_load     = i_valid && !o_stall;

    nhfst_slot_update #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_update (
        .i_kind      (r_kind),
        .i_site      (r_site),
        .i_count     (r_count),
        .i_slot_site (r_slot_site),
        .i_slot_cnt  (r_slot_cnt),
        .o_slot_site (n_slot_site),
        .o_slot_cnt  (n_slot_cnt),
        .o_fire      (n_fire)
    );

    // control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_slot_site <= '0;
            r_slot_cnt  <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (!out_blocked) begin
                r_out_valid <= r_in_valid;
            end
            // table commits exactly once per item, as it moves to the result stage
            if (advance) begin
                r_slot_site <= n_slot_site;
                r_slot_cnt  <= n_slot_cnt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_kind  <= i_kind;
            r_site  <= i_site;
            r_count <= i_count;
        end
        if (advance) begin
            r_fire <= n_fire;
        end
    end

    assign o_valid = r_out_valid;
    assign o_fire  = r_fire;

endmodule
